// ===== hdl/breakpoint_patch_table_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef BREAKPOINT_PATCH_TABLE_CORE_ASSERT_SVH
`define BREAKPOINT_PATCH_TABLE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/bpt_pkg.sv =====
package bpt_pkg;

  localparam int AddrW          = 64;
  localparam int WordW          = 64;
  localparam int ByteW          = 8;
  localparam int SlotW          = 4;
  localparam int EntriesDefault = 16;
  localparam logic [ByteW-1:0] TrapByteReset = 8'hCC;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_DISABLE = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_REMOVE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_DUP         = 3'd1,
    STATUS_FULL        = 3'd2,
    STATUS_NOT_FOUND   = 3'd3,
    STATUS_WRONG_STATE = 3'd4,
    STATUS_READ_FAIL   = 3'd5,
    STATUS_WRITE_FAIL  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_ALLOC,
    UPD_ENABLE,
    UPD_DISABLE,
    UPD_FREE
  } upd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

endpackage

// ===== hdl/bpt_if.sv =====
interface bpt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] addr;
  logic [63:0] mem_word;
  logic        read_ok;
  logic        write_ok;

  modport source (output valid, req_type, addr, mem_word, read_ok, write_ok, input ready);
  modport sink   (input valid, req_type, addr, mem_word, read_ok, write_ok, output ready);
endinterface

interface bpt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic        write_en;
  logic [63:0] write_word;

  modport source (output valid, status, slot, write_en, write_word, input ready);
  modport sink   (input valid, status, slot, write_en, write_word, output ready);
endinterface

interface bpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] trap_byte;

  modport source (output valid, trap_byte, input ready);
  modport sink   (input valid, trap_byte, output ready);
endinterface

// ===== hdl/bpt_cell.sv =====
module bpt_cell import bpt_pkg::*; #(
  parameter int  IdxW    = 4,
  parameter int  CellIdx = 0,
  parameter type scan_t  = logic,
  parameter type upd_t   = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [AddrW-1:0] req_addr_i,
  input  upd_t             upd_i,
  input  scan_t            tok_i,
  output scan_t            tok_o
);

  logic             valid_q, valid_d;
  logic             enabled_q, enabled_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [ByteW-1:0] byte_q, byte_d;
  scan_t            tok_q, tok_d;
  logic             sel;

  assign sel = (upd_i.idx == IdxW'(CellIdx));

  always_comb begin
    valid_d   = valid_q;
    enabled_d = enabled_q;
    addr_d    = addr_q;
    byte_d    = byte_q;
    if (sel) begin
      unique case (upd_i.kind)
        UPD_ALLOC: begin
          valid_d   = 1'b1;
          enabled_d = 1'b1;
          addr_d    = upd_i.addr;
          byte_d    = upd_i.saved;
        end
        UPD_ENABLE:  enabled_d = 1'b1;
        UPD_DISABLE: enabled_d = 1'b0;
        UPD_FREE: begin
          valid_d   = 1'b0;
          enabled_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // The first matching entry and the first free entry along the chain win.
  always_comb begin
    tok_d = tok_i;
    if (!tok_i.hit && valid_q && (addr_q == req_addr_i)) begin
      tok_d.hit      = 1'b1;
      tok_d.hit_idx  = IdxW'(CellIdx);
      tok_d.hit_en   = enabled_q;
      tok_d.hit_byte = byte_q;
    end
    if (!tok_i.free && !valid_q) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = IdxW'(CellIdx);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      enabled_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      valid_q   <= valid_d;
      enabled_q <= enabled_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    byte_q <= byte_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/bpt_ctrl.sv =====
module bpt_ctrl import bpt_pkg::*; #(
  parameter int  IdxW   = 4,
  parameter type scan_t = logic,
  parameter type upd_t  = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bpt_req_if.sink          req_i,
  bpt_rsp_if.source        rsp_o,
  bpt_cfg_if.sink          cfg_i,
  output logic [AddrW-1:0] req_addr_o,
  output scan_t            tok_o,
  input  scan_t            tok_i,
  output upd_t             upd_o
);

  state_e           state_q, state_d;
  logic             launch_q;
  logic [ByteW-1:0] trap_q;
  op_e              op_q;
  logic [AddrW-1:0] addr_q;
  logic [WordW-1:0] word_q;
  logic             rd_q, wr_q;
  scan_t            res_q;

  logic             out_valid_q;
  status_e          out_status_q, status_d;
  logic [SlotW-1:0] out_slot_q, slot_d;
  logic             out_wen_q, wen_d;
  logic [WordW-1:0] out_word_q, word_d;

  logic accept, out_free, fire, want_en;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign fire     = (state_q == ST_DECIDE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_i.valid) state_d = ST_SCAN;
      ST_SCAN:   if (tok_i.live) state_d = ST_DECIDE;
      ST_DECIDE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    cfg_i.ready = 1'b1;
  end

  always_comb begin
    tok_o      = '0;
    tok_o.live = launch_q;
  end

  assign req_addr_o = addr_q;
  assign want_en    = (op_q == OP_ENABLE);

  always_comb begin
    status_d    = STATUS_OK;
    slot_d      = '0;
    wen_d       = 1'b0;
    word_d      = '0;
    upd_o       = '0;
    upd_o.kind  = UPD_NONE;
    upd_o.addr  = addr_q;
    upd_o.saved = word_q[ByteW-1:0];
    unique case (op_q)
      OP_SET: begin
        if (res_q.hit) begin
          status_d = STATUS_DUP;
          slot_d   = SlotW'(res_q.hit_idx);
        end else if (!res_q.free) begin
          status_d = STATUS_FULL;
        end else if (!rd_q) begin
          status_d = STATUS_READ_FAIL;
        end else if (!wr_q) begin
          status_d = STATUS_WRITE_FAIL;
        end else begin
          slot_d     = SlotW'(res_q.free_idx);
          wen_d      = 1'b1;
          word_d     = {word_q[WordW-1:ByteW], trap_q};
          upd_o.kind = UPD_ALLOC;
          upd_o.idx  = res_q.free_idx;
        end
      end
      OP_REMOVE: begin
        if (!res_q.hit) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          slot_d     = SlotW'(res_q.hit_idx);
          upd_o.kind = UPD_FREE;
          upd_o.idx  = res_q.hit_idx;
          // A failed restore is ignored; the entry is freed anyway.
          if (res_q.hit_en && rd_q && wr_q) begin
            wen_d  = 1'b1;
            word_d = {word_q[WordW-1:ByteW], res_q.hit_byte};
          end
        end
      end
      OP_DISABLE, OP_ENABLE: begin
        if (!res_q.hit) begin
          status_d = STATUS_NOT_FOUND;
        end else begin
          slot_d = SlotW'(res_q.hit_idx);
          if (res_q.hit_en == want_en) begin
            status_d = STATUS_WRONG_STATE;
          end else if (!rd_q) begin
            status_d = STATUS_READ_FAIL;
          end else if (!wr_q) begin
            status_d = STATUS_WRITE_FAIL;
          end else begin
            wen_d      = 1'b1;
            word_d     = {word_q[WordW-1:ByteW], want_en ? trap_q : res_q.hit_byte};
            upd_o.kind = want_en ? UPD_ENABLE : UPD_DISABLE;
            upd_o.idx  = res_q.hit_idx;
          end
        end
      end
      default: ;
    endcase
    if (!fire) begin
      upd_o.kind = UPD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      trap_q      <= TrapByteReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= accept;
      if (cfg_i.valid && cfg_i.ready) begin
        trap_q <= cfg_i.trap_byte;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= op_e'(req_i.req_type);
      addr_q <= req_i.addr;
      word_q <= req_i.mem_word;
      rd_q   <= req_i.read_ok;
      wr_q   <= req_i.write_ok;
    end
    if ((state_q == ST_SCAN) && tok_i.live) begin
      res_q <= tok_i;
    end
    if (fire) begin
      out_status_q <= status_d;
      out_slot_q   <= slot_d;
      out_wen_q    <= wen_d;
      out_word_q   <= word_d;
    end
  end

  always_comb begin
    rsp_o.valid      = out_valid_q;
    rsp_o.status     = out_status_q;
    rsp_o.slot       = out_slot_q;
    rsp_o.write_en   = out_wen_q;
    rsp_o.write_word = out_word_q;
  end

endmodule

// ===== hdl/breakpoint_patch_table_core.sv =====
// Breakpoint table with ENTRIES slots held in a chain of cells. Each accepted request word
// sends a search token down the chain, one cell per cycle, collecting the lowest entry that
// holds the address and the lowest free entry; the controller then decides the result and, on
// success, updates the chosen cell. A new request is taken only after the previous one has
// passed the whole cell chain and its result has been decided. A finished result sits in an
// output register, so the next request is accepted while it waits. The trap byte resets to
// 0xCC and may be rewritten through the configuration channel while no request is in flight.
module breakpoint_patch_table_core import bpt_pkg::*; #(
  parameter int ENTRIES = EntriesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bpt_req_if.sink   req_i,
  bpt_rsp_if.source rsp_o,
  bpt_cfg_if.sink   cfg_i
);

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef struct packed {
    logic             live;
    logic             hit;
    logic [IdxW-1:0]  hit_idx;
    logic             hit_en;
    logic [ByteW-1:0] hit_byte;
    logic             free;
    logic [IdxW-1:0]  free_idx;
  } scan_t;

  typedef struct packed {
    upd_e             kind;
    logic [IdxW-1:0]  idx;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] saved;
  } upd_t;

  scan_t            tok [ENTRIES+1];
  upd_t             upd;
  logic [AddrW-1:0] req_addr;

  bpt_ctrl #(
    .IdxW   (IdxW),
    .scan_t (scan_t),
    .upd_t  (upd_t)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .cfg_i      (cfg_i),
    .req_addr_o (req_addr),
    .tok_o      (tok[0]),
    .tok_i      (tok[ENTRIES]),
    .upd_o      (upd)
  );

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    bpt_cell #(
      .IdxW    (IdxW),
      .CellIdx (i),
      .scan_t  (scan_t),
      .upd_t   (upd_t)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .req_addr_i (req_addr),
      .upd_i      (upd),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
  end

endmodule

// ===== hdl/bpt_checker.sv =====
`include "breakpoint_patch_table_core_assert.svh"

module bpt_checker import bpt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [2:0]       status_i,
  input logic [SlotW-1:0] slot_i,
  input logic             write_en_i,
  input logic [WordW-1:0] write_word_i
);

  logic req_acc, rsp_hold;

  assign req_acc  = req_valid_i && req_ready_i;
  assign rsp_hold = rsp_valid_i && !rsp_ready_i;

  // One request at a time: the input closes right after a word is taken.
  `BPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_acc, !req_ready_i)

  // A memory write is only requested by a successful operation.
  `BPT_ASSERT_SAME(a_wen_ok, clk_i, rst_ni, rsp_valid_i && write_en_i, status_i == STATUS_OK)

  // Failures carry no write and a zero word.
  `BPT_ASSERT_SAME(a_fail_quiet, clk_i, rst_ni, rsp_valid_i && (status_i != STATUS_OK),
    !write_en_i && (write_word_i == '0))

  // Not found and full name no entry.
  `BPT_ASSERT_SAME(a_no_slot, clk_i, rst_ni,
    rsp_valid_i && ((status_i == STATUS_NOT_FOUND) || (status_i == STATUS_FULL)),
    slot_i == '0)

  `BPT_ASSERT_NEXT(a_rsp_stable, clk_i, rst_ni, rsp_hold,
    rsp_valid_i && $stable(status_i) && $stable(slot_i) && $stable(write_word_i))

endmodule

bind breakpoint_patch_table_core bpt_checker u_bpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .slot_i       (rsp_o.slot),
  .write_en_i   (rsp_o.write_en),
  .write_word_i (rsp_o.write_word)
);
